@@ hw/rtl/rcbp_pkg.sv @@
// ----------------------------------------------------------------------------
// rcbp_pkg
// Shared request/response types and codes for the buffer pool core.
// ----------------------------------------------------------------------------
package rcbp_pkg;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_GET   = 2'd1;
   localparam logic [1:0] CMD_PUT   = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;

   localparam logic [2:0] STATUS_OK           = 3'd0;
   localparam logic [2:0] STATUS_BAD_CAPACITY = 3'd1;
   localparam logic [2:0] STATUS_POOL_EMPTY   = 3'd2;
   localparam logic [2:0] STATUS_NULL_HANDLE  = 3'd3;
   localparam logic [2:0] STATUS_NOT_LIVE     = 3'd4;
   localparam logic [2:0] STATUS_COUNT_FULL   = 3'd5;
   localparam logic [2:0] STATUS_UNDERFLOW    = 3'd6;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] capacity;
      logic [6:0]  handle;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  result_handle;
      logic [15:0] ref_count;
      logic        released;
      logic [6:0]  free_available;
   } rsp_type;

endpackage

@@ hw/rtl/refcounted_buffer_pool_core.sv @@
// ----------------------------------------------------------------------------
// refcounted_buffer_pool_core
// Reference-counted packet buffer manager: LIFO free stack plus a reference
// count per buffer. Takes one request per cycle while req_stall is low; each
// request is held in the request register, then its result in the result
// register. The two RAM reads for a request are issued as it is accepted,
// with forwarding from the request ahead of it. req_stall is also high while a
// result is held off by rsp_stall and a request is waiting behind it.
// After reset a clearing pass zeroes each entry of the count RAM in turn,
// during which req_stall is high.
// A buffer is live exactly when its count is non-zero.
// ----------------------------------------------------------------------------
module refcounted_buffer_pool_core #(
   parameter int unsigned POOL_SIZE    = 64,
   parameter int unsigned MAX_CAPACITY = 2048,
   parameter int unsigned COUNT_BITS   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rcbp_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rcbp_pkg::rsp_type rsp_payload
);

   localparam int unsigned IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int unsigned FC_W  = $clog2(POOL_SIZE + 1);

   // clearing pass
   logic             clr_busy_ff, clr_busy_in;
   logic [IDX_W-1:0] clr_addr_ff, clr_addr_in;

   // execute stage
   logic              s1_valid_ff, s1_valid_in;
   rcbp_pkg::req_type s1_req_ff;
   logic              stk_byp_ff, stk_fresh_ff, cnt_byp_ff;
   logic [IDX_W-1:0]  stk_byp_data_ff, stk_raddr_ff;
   logic [COUNT_BITS-1:0] cnt_byp_data_ff;

   logic [FC_W-1:0] fc_ff, fc_in, fc_next;
   logic [FC_W-1:0] low_mark_ff, low_mark_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rcbp_pkg::rsp_type rsp_payload_ff;

   logic accept, out_ready, s1_fire;

   // RAM ports
   logic [IDX_W-1:0]      stk_q, stk_raddr_in, stk_waddr, stk_wdata;
   logic                  stk_we;
   logic [COUNT_BITS-1:0] cnt_q, cnt_wdata, ex_cnt_wdata;
   logic [IDX_W-1:0]      cnt_raddr_in, cnt_waddr, ex_cnt_waddr;
   logic                  cnt_we, ex_cnt_we, ex_stk_we;

   // execute logic
   logic [6:0]            idx7;
   logic                  idx_ok, live;
   logic [IDX_W-1:0]      idx, stk_val;
   logic [COUNT_BITS-1:0] cnt_val, cnt_dec;
   rcbp_pkg::rsp_type     res;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_ready;
   assign req_stall = clr_busy_ff || (s1_valid_ff && !out_ready);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      idx7    = s1_req_ff.handle - 7'd1;
      idx_ok  = 32'(idx7) < POOL_SIZE;
      idx     = IDX_W'(idx7);
      stk_val = stk_byp_ff ? stk_byp_data_ff : (stk_fresh_ff ? stk_raddr_ff : stk_q);
      cnt_val = cnt_byp_ff ? cnt_byp_data_ff : cnt_q;
      live    = idx_ok && (cnt_val != '0);
      cnt_dec = cnt_val - COUNT_BITS'(1);

      fc_next      = fc_ff;
      ex_cnt_we    = 1'b0;
      ex_cnt_waddr = idx;
      ex_cnt_wdata = cnt_dec;
      ex_stk_we    = 1'b0;
      stk_waddr    = IDX_W'(fc_ff);
      stk_wdata    = idx;

      res.status         = rcbp_pkg::STATUS_OK;
      res.result_handle  = 7'd0;
      res.ref_count      = 16'd0;
      res.released       = 1'b0;

      case (s1_req_ff.command)
         rcbp_pkg::CMD_ALLOC: begin
            if (s1_req_ff.capacity == 16'd0 || 32'(s1_req_ff.capacity) > MAX_CAPACITY) begin
               res.status = rcbp_pkg::STATUS_BAD_CAPACITY;
            end else if (fc_ff == '0) begin
               res.status = rcbp_pkg::STATUS_POOL_EMPTY;
            end else begin
               fc_next           = fc_ff - FC_W'(1);
               ex_cnt_we         = 1'b1;
               ex_cnt_waddr      = stk_val;
               ex_cnt_wdata      = COUNT_BITS'(1);
               res.result_handle = 7'(32'(stk_val) + 32'd1);
               res.ref_count     = 16'd1;
            end
         end
         rcbp_pkg::CMD_GET: begin
            if (s1_req_ff.handle == 7'd0) begin
               res.status = rcbp_pkg::STATUS_NULL_HANDLE;
            end else if (!live) begin
               res.status = rcbp_pkg::STATUS_NOT_LIVE;
            end else if (cnt_val == '1) begin
               res.status    = rcbp_pkg::STATUS_COUNT_FULL;
               res.ref_count = 16'(cnt_val);
            end else begin
               ex_cnt_we         = 1'b1;
               ex_cnt_wdata      = cnt_val + COUNT_BITS'(1);
               res.result_handle = s1_req_ff.handle;
               res.ref_count     = 16'(cnt_val + COUNT_BITS'(1));
            end
         end
         rcbp_pkg::CMD_PUT: begin
            if (s1_req_ff.handle == 7'd0) begin
               res.status = rcbp_pkg::STATUS_NULL_HANDLE;
            end else if (!live) begin
               res.status = rcbp_pkg::STATUS_UNDERFLOW;
            end else begin
               ex_cnt_we         = 1'b1;
               res.result_handle = s1_req_ff.handle;
               res.ref_count     = 16'(cnt_dec);
               if (cnt_dec == '0) begin
                  res.released = 1'b1;
                  if (32'(fc_ff) < POOL_SIZE) begin
                     ex_stk_we = 1'b1;
                     fc_next   = fc_ff + FC_W'(1);
                  end
               end
            end
         end
         default: begin
         end
      endcase

      res.free_available = 7'(fc_next);
   end

   // state updates and forwarding for the request being accepted
   always_comb begin
      fc_in        = s1_fire ? fc_next : fc_ff;
      low_mark_in  = (fc_in < low_mark_ff) ? fc_in : low_mark_ff;
      stk_raddr_in = IDX_W'(fc_in - FC_W'(1));
      cnt_raddr_in = IDX_W'(req_payload.handle - 7'd1);

      stk_we    = s1_fire && ex_stk_we;
      cnt_we    = clr_busy_ff || (s1_fire && ex_cnt_we);
      cnt_waddr = clr_busy_ff ? clr_addr_ff : ex_cnt_waddr;
      cnt_wdata = clr_busy_ff ? '0 : ex_cnt_wdata;

      clr_addr_in = clr_addr_ff + IDX_W'(1);
      clr_busy_in = clr_busy_ff && (32'(clr_addr_ff) != POOL_SIZE - 1);

      s1_valid_in  = accept || (s1_valid_ff && !s1_fire);
      rsp_valid_in = out_ready ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fc_ff        <= FC_W'(POOL_SIZE);
         low_mark_ff  <= FC_W'(POOL_SIZE);
      end else begin
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_in;
         end
         clr_busy_ff  <= clr_busy_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fc_ff        <= fc_in;
         low_mark_ff  <= low_mark_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff       <= req_payload;
         stk_raddr_ff    <= stk_raddr_in;
         stk_fresh_ff    <= (fc_in == low_mark_in);
         stk_byp_ff      <= stk_we && (stk_waddr == stk_raddr_in);
         stk_byp_data_ff <= stk_wdata;
         cnt_byp_ff      <= cnt_we && (cnt_waddr == cnt_raddr_in);
         cnt_byp_data_ff <= cnt_wdata;
      end
      if (s1_fire) begin
         rsp_payload_ff <= res;
      end
   end

   rcbp_ram #(
      .WIDTH (IDX_W),
      .DEPTH (POOL_SIZE)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (accept),
      .rd_addr (stk_raddr_in),
      .rd_data (stk_q)
   );

   rcbp_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (POOL_SIZE)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (accept),
      .rd_addr (cnt_raddr_in),
      .rd_data (cnt_q)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ hw/rtl/rcbp_ram.sv @@
// ----------------------------------------------------------------------------
// rcbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcbp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/rcbp_checker.sv @@
// ----------------------------------------------------------------------------
// rcbp_checker
// Port-level checks on the buffer pool core, bound to each core instance.
// ----------------------------------------------------------------------------
module rcbp_checker #(
   parameter int unsigned POOL_SIZE = 64
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input rcbp_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rcbp_pkg::rsp_type rsp_payload
);

   // a release is always a successful drop with nothing left
   a_release_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.released |->
         rsp_payload.status == rcbp_pkg::STATUS_OK && rsp_payload.ref_count == 16'd0)
      else $error("release with bad status or count");

   // failures carry no handle and never release
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != rcbp_pkg::STATUS_OK |->
         rsp_payload.result_handle == 7'd0 && !rsp_payload.released)
      else $error("failed request reports a handle or release");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_payload.free_available) <= POOL_SIZE)
      else $error("free count above pool size");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

endmodule

bind refcounted_buffer_pool_core rcbp_checker #(.POOL_SIZE(POOL_SIZE)) u_rcbp_checker (.*);
